@@ rtl/gcdb_pkg.sv @@
// ----------------------------------------------------------------------------
// Great-circle distance and bearing: shared package
// Datapath widths, CORDIC arctangent table and the per-step functions used by
// the pipelined rotation CORDIC, vectoring CORDIC and integer square root.
// ----------------------------------------------------------------------------
package gcdb_pkg;

	// Sin/cos and derived Q30 values
	localparam int CS_W = 34;
	// Vectoring CORDIC datapath
	localparam int VEC_W = 36;
	// Square root operand
	localparam int ROOT_W = 64;
	localparam int ROOT_STEPS = 32;
	// Bearing result waits this many stages for the distance path
	localparam int BRG_DLY = 36;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic signed [CS_W-1:0] GAIN_Q30 = 34'sd652032874;
	// 60 nmi per degree times 360 degrees per turn
	localparam logic [14:0] NMI_DEG_PER_TURN = 15'd21600;
	localparam logic [15:0] ROUND_HALF = 16'h8000;
	localparam logic [30:0] CENTRAL_MAX = 31'h7FFF_FFFF;
	localparam logic [29:0] DIST_MAX = 30'd707788800;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [CS_W-1:0] x;
		logic signed [CS_W-1:0] y;
		logic signed [CS_W-1:0] z;
		logic flip;
	} rot_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [31:0] z;
		logic zero;
	} vec_t;

	typedef struct packed {
		logic [ROOT_W-1:0] v;
		logic [ROOT_W-1:0] r;
	} root_t;

	// Fold the angle into +-90 degrees and load the gain-compensated vector
	function automatic rot_t rot_init(input logic [31:0] a);
		rot_t o;
		logic [31:0] sum;
		logic [31:0] ar;
		sum = a + QUARTER_TURN;
		o.flip = (sum > HALF_TURN);
		ar = o.flip ? a + HALF_TURN : a;
		o.x = GAIN_Q30;
		o.y = '0;
		o.z = $signed({{(CS_W-32){ar[31]}}, ar});
		return o;
	endfunction

	// One rotation micro-step, driven by the sign of the residual angle
	function automatic rot_t rot_step(input rot_t i, input logic [4:0] k);
		rot_t o;
		logic signed [CS_W-1:0] dx;
		logic signed [CS_W-1:0] dy;
		logic signed [CS_W-1:0] at;
		dx = i.y >>> k;
		dy = i.x >>> k;
		at = $signed({{(CS_W-32){1'b0}}, ATAN_TURNS[k]});
		o = i;
		if (!i.z[CS_W-1]) begin
			o.x = i.x - dx;
			o.y = i.y + dy;
			o.z = i.z - at;
		end else begin
			o.x = i.x + dx;
			o.y = i.y - dy;
			o.z = i.z + at;
		end
		return o;
	endfunction

	// Turn a left-half-plane vector by 180 degrees; flag the zero vector
	function automatic vec_t vec_init(input logic signed [VEC_W-1:0] y,
			input logic signed [VEC_W-1:0] x);
		vec_t o;
		o.zero = (x == '0) && (y == '0);
		if (x[VEC_W-1]) begin
			o.x = -x;
			o.y = -y;
			o.z = HALF_TURN;
		end else begin
			o.x = x;
			o.y = y;
			o.z = '0;
		end
		return o;
	endfunction

	// One vectoring micro-step, driving y toward zero
	function automatic vec_t vec_step(input vec_t i, input logic [4:0] k);
		vec_t o;
		logic signed [VEC_W-1:0] dx;
		logic signed [VEC_W-1:0] dy;
		dx = i.y >>> k;
		dy = i.x >>> k;
		o = i;
		if (!i.y[VEC_W-1] && (i.y != '0)) begin
			o.x = i.x + dx;
			o.y = i.y - dy;
			o.z = i.z + ATAN_TURNS[k];
		end else begin
			o.x = i.x - dx;
			o.y = i.y + dy;
			o.z = i.z - ATAN_TURNS[k];
		end
		return o;
	endfunction

	// One digit of the restoring integer square root
	function automatic root_t root_step(input root_t i, input logic [4:0] k);
		root_t o;
		logic [5:0] sh;
		logic [ROOT_W-1:0] b;
		logic [ROOT_W-1:0] rb;
		sh = 6'd62 - {k, 1'b0};
		b = ROOT_W'(1) << sh;
		rb = i.r + b;
		if (i.v >= rb) begin
			o.v = i.v - rb;
			o.r = (i.r >> 1) + b;
		end else begin
			o.v = i.v;
			o.r = i.r >> 1;
		end
		return o;
	endfunction

	// Q30 product, floored back to Q30
	function automatic logic signed [CS_W-1:0] mul_q30(input logic signed [CS_W-1:0] a,
			input logic signed [CS_W-1:0] b);
		logic signed [2*CS_W-1:0] p;
		p = a * b;
		return CS_W'(p >>> 30);
	endfunction

	// Radius (Q12.12) times Q30 unit component, giving Q18 nautical miles
	function automatic logic signed [CS_W-1:0] mul_rad(input logic signed [24:0] r,
			input logic signed [CS_W-1:0] u);
		logic signed [CS_W+24:0] p;
		p = r * u;
		return CS_W'(p >>> 24);
	endfunction

endpackage

@@ rtl/great_circle_distance_bearing.sv @@
// Throughput: one item per cycle; the CORDIC, multiply and square-root stages
// are fully pipelined, so the rate is set by the single global stage enable.
// A result held at the output stalls every stage at once; nothing is dropped.
// Reset clears all valid bits and loads the sphere radius with 14106492.
// ----------------------------------------------------------------------------
// Great-circle distance and initial bearing
// Places both points on a sphere, forms the chord, finds the central angle
// with a half-angle atan2 and the bearing with a second atan2, all pipelined.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [23:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] start_latitude,
	input  logic signed [31:0] start_longitude,
	input  logic signed [31:0] end_latitude,
	input  logic signed [31:0] end_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [30:0]        central_angle,
	output logic [29:0]        distance_nmi,
	output logic [31:0]        bearing
);

	localparam int CS_W = gcdb_pkg::CS_W;
	localparam int VEC_W = gcdb_pkg::VEC_W;
	localparam int NS = CORDIC_STAGES;
	localparam int RS = gcdb_pkg::ROOT_STEPS;
	localparam int BD = gcdb_pkg::BRG_DLY;
	// rotation, sin/cos, math stages, root, vectoring, two output stages
	localparam int LAT = 1 + NS + 1 + 5 + 1 + RS + 1 + NS + 1 + 1;

	// CORDIC lanes
	localparam int LN_LAT1 = 0;
	localparam int LN_LON1 = 1;
	localparam int LN_LAT2 = 2;
	localparam int LN_LON2 = 3;
	localparam int LN_DLON = 4;
	localparam int LANES = 5;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic [23:0] radius_q;
	logic signed [24:0] rad;
	logic [31:0] ang [LANES];

	gcdb_pkg::rot_t rot_s [LANES][NS+1];
	logic signed [CS_W-1:0] cos_s1 [LANES];
	logic signed [CS_W-1:0] sin_s1 [LANES];

	logic signed [CS_W-1:0] ux1_s2, ux2_s2, uy1_s2, uy2_s2, pz1_s2, pz2_s2;
	logic signed [CS_W-1:0] e_s2, t_s2, sl1_s2;
	logic signed [2*CS_W-1:0] pcs_s2;

	logic signed [CS_W-1:0] px1_s3, px2_s3, py1_s3, py2_s3, pz1_s3, pz2_s3, e_s3;
	logic signed [2*CS_W-1:0] pcs_s3, pst_s3;
	logic signed [2*CS_W-1:0] ndiff;

	logic signed [CS_W-1:0] dx_s4, dy_s4, dz_s4, n_s4, e_s4;
	logic signed [2*CS_W-1:0] sqx, sqy, sqz;
	logic [59:0] r2p;

	logic [63:0] dxx_s5, dyy_s5, dzz_s5, r2_s5;
	logic [63:0] sum_s6, r2_s6;
	logic [63:0] q_w, a2_w;

	gcdb_pkg::root_t hr_s [RS+1];
	gcdb_pkg::root_t ar_s [RS+1];

	gcdb_pkg::vec_t cv_s [NS+1];
	gcdb_pkg::vec_t bv_s [NS+1];
	logic [31:0] bdl_s [BD];

	logic [31:0] hb;
	logic [30:0] cen_s;
	logic [45:0] dprod;
	logic [30:0] central_q;
	logic [29:0] dist_q;
	logic [31:0] bearing_q;

	// Whole pipeline moves unless a result waits at the output
	assign adv = !vld_q[LAT-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[LAT-1];

	// Hold control state: valid bits and radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			radius_q <= 24'd14106492;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[LAT-2:0], in_valid};
			end
			if (cfg_wr_en) begin
				radius_q <= cfg_wr_data;
			end
		end
	end

	assign rad = $signed({1'b0, radius_q});

	assign ang[LN_LAT1] = start_latitude;
	assign ang[LN_LON1] = start_longitude;
	assign ang[LN_LAT2] = end_latitude;
	assign ang[LN_LON2] = end_longitude;
	assign ang[LN_DLON] = end_longitude - start_longitude;

	// Rotation CORDIC lanes for all sines and cosines
	for (genvar l = 0; l < LANES; l++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv) begin
				rot_s[l][0] <= gcdb_pkg::rot_init(ang[l]);
			end
		end
		for (genvar k = 0; k < NS; k++) begin : g_step
			always_ff @(posedge clk) begin
				if (adv) begin
					rot_s[l][k+1] <= gcdb_pkg::rot_step(rot_s[l][k], 5'(k));
				end
			end
		end
		// Undo the half-turn fold
		always_ff @(posedge clk) begin
			if (adv) begin
				cos_s1[l] <= rot_s[l][NS].flip ? -rot_s[l][NS].x : rot_s[l][NS].x;
				sin_s1[l] <= rot_s[l][NS].flip ? -rot_s[l][NS].y : rot_s[l][NS].y;
			end
		end
	end

	// Unit vector components, z positions and bearing terms
	always_ff @(posedge clk) begin
		if (adv) begin
			ux1_s2 <= gcdb_pkg::mul_q30(cos_s1[LN_LAT1], cos_s1[LN_LON1]);
			ux2_s2 <= gcdb_pkg::mul_q30(cos_s1[LN_LAT2], cos_s1[LN_LON2]);
			uy1_s2 <= gcdb_pkg::mul_q30(cos_s1[LN_LAT1], sin_s1[LN_LON1]);
			uy2_s2 <= gcdb_pkg::mul_q30(cos_s1[LN_LAT2], sin_s1[LN_LON2]);
			pz1_s2 <= gcdb_pkg::mul_rad(rad, sin_s1[LN_LAT1]);
			pz2_s2 <= gcdb_pkg::mul_rad(rad, sin_s1[LN_LAT2]);
			e_s2 <= gcdb_pkg::mul_q30(sin_s1[LN_DLON], cos_s1[LN_LAT2]);
			t_s2 <= gcdb_pkg::mul_q30(cos_s1[LN_LAT2], cos_s1[LN_DLON]);
			pcs_s2 <= cos_s1[LN_LAT1] * sin_s1[LN_LAT2];
			sl1_s2 <= sin_s1[LN_LAT1];
		end
	end

	// Scale by radius; second bearing product
	always_ff @(posedge clk) begin
		if (adv) begin
			px1_s3 <= gcdb_pkg::mul_rad(rad, ux1_s2);
			px2_s3 <= gcdb_pkg::mul_rad(rad, ux2_s2);
			py1_s3 <= gcdb_pkg::mul_rad(rad, uy1_s2);
			py2_s3 <= gcdb_pkg::mul_rad(rad, uy2_s2);
			pz1_s3 <= pz1_s2;
			pz2_s3 <= pz2_s2;
			e_s3 <= e_s2;
			pcs_s3 <= pcs_s2;
			pst_s3 <= sl1_s2 * t_s2;
		end
	end

	assign ndiff = pcs_s3 - pst_s3;

	// Chord components and north term
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s4 <= px2_s3 - px1_s3;
			dy_s4 <= py2_s3 - py1_s3;
			dz_s4 <= pz2_s3 - pz1_s3;
			n_s4 <= CS_W'(ndiff >>> 30);
			e_s4 <= e_s3;
		end
	end

	assign sqx = dx_s4 * dx_s4;
	assign sqy = dy_s4 * dy_s4;
	assign sqz = dz_s4 * dz_s4;
	assign r2p = {radius_q, 6'b0} * {radius_q, 6'b0};

	// Squares of the chord components and of the scaled radius
	always_ff @(posedge clk) begin
		if (adv) begin
			dxx_s5 <= sqx[63:0];
			dyy_s5 <= sqy[63:0];
			dzz_s5 <= sqz[63:0];
			r2_s5 <= {4'b0, r2p};
		end
	end

	// Squared chord
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s6 <= dxx_s5 + dyy_s5 + dzz_s5;
			r2_s6 <= r2_s5;
		end
	end

	assign q_w = {2'b00, sum_s6[63:2]};
	assign a2_w = (r2_s6 > q_w) ? r2_s6 - q_w : '0;

	// Half chord and adjacent side, one root digit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			hr_s[0] <= '{v: q_w, r: '0};
			ar_s[0] <= '{v: a2_w, r: '0};
		end
	end

	for (genvar k = 0; k < RS; k++) begin : g_root
		always_ff @(posedge clk) begin
			if (adv) begin
				hr_s[k+1] <= gcdb_pkg::root_step(hr_s[k], 5'(k));
				ar_s[k+1] <= gcdb_pkg::root_step(ar_s[k], 5'(k));
			end
		end
	end

	// Half central angle from the two roots; bearing vector from the north and east terms
	always_ff @(posedge clk) begin
		if (adv) begin
			cv_s[0] <= gcdb_pkg::vec_init(
				$signed({{(VEC_W-32){1'b0}}, hr_s[RS].r[31:0]}),
				$signed({{(VEC_W-32){1'b0}}, ar_s[RS].r[31:0]}));
			bv_s[0] <= gcdb_pkg::vec_init(
				$signed({{(VEC_W-CS_W){n_s4[CS_W-1]}}, n_s4}),
				$signed({{(VEC_W-CS_W){e_s4[CS_W-1]}}, e_s4}));
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_vec
		always_ff @(posedge clk) begin
			if (adv) begin
				cv_s[k+1] <= gcdb_pkg::vec_step(cv_s[k], 5'(k));
				bv_s[k+1] <= gcdb_pkg::vec_step(bv_s[k], 5'(k));
			end
		end
	end

	// Bearing from north, then delay to meet the distance result
	always_ff @(posedge clk) begin
		if (adv) begin
			bdl_s[0] <= gcdb_pkg::QUARTER_TURN - (bv_s[NS].zero ? 32'd0 : bv_s[NS].z);
		end
	end

	for (genvar j = 1; j < BD; j++) begin : g_bdl
		always_ff @(posedge clk) begin
			if (adv) begin
				bdl_s[j] <= bdl_s[j-1];
			end
		end
	end

	// Double the half angle: drop residue below zero, saturate at a half turn
	assign hb = cv_s[NS].zero ? 32'd0 : cv_s[NS].z;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (hb[31]) begin
				cen_s <= '0;
			end else if (hb[30]) begin
				cen_s <= gcdb_pkg::CENTRAL_MAX;
			end else begin
				cen_s <= {hb[29:0], 1'b0};
			end
		end
	end

	assign dprod = 46'(cen_s) * 46'(gcdb_pkg::NMI_DEG_PER_TURN)
		+ 46'(gcdb_pkg::ROUND_HALF);

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			central_q <= cen_s;
			dist_q <= dprod[45:16];
			bearing_q <= bdl_s[BD-1];
		end
	end

	assign central_angle = central_q;
	assign distance_nmi = dist_q;
	assign bearing = bearing_q;

`ifndef SYNTHESIS
	// Zero angle must give zero distance
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (central_angle == '0) |-> (distance_nmi == '0))
		else $error("nonzero distance for zero central angle");

	// Distance stays within a half circumference
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (distance_nmi <= gcdb_pkg::DIST_MAX))
		else $error("distance out of range");

	// A stall freezes every valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved during stall");

	// Roots of 64-bit operands fit in 32 bits
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS+RS+7] |-> (hr_s[RS].r[63:32] == '0) && (ar_s[RS].r[63:32] == '0))
		else $error("square root exceeds 32 bits");
`endif

endmodule

@@ dv/great_circle_distance_bearing_tb.sv @@
// ----------------------------------------------------------------------------
// Great-circle distance and bearing testbench
// Drives point pairs through the valid/ready input with random gaps, stalls
// the result side at random and compares central angle, distance and bearing
// against a bit-exact CORDIC/square-root predictor for several sphere radii.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 24;
	localparam int LATENCY = 2*STAGES + 43;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [23:0] RADIUS_RESET = 24'd14106492;
	localparam logic [23:0] RADIUS_MAX = 24'hFFFFFF;
	localparam logic [23:0] RADIUS_MIN = 24'd1;
	localparam int LAT_MAX = 32'sh4000_0000;
	localparam int LAT_MIN = -32'sh4000_0000;
	localparam int LON_MAX = 32'sh7FFF_FFFF;
	localparam int LON_MIN = 32'sh8000_0000;

	typedef struct {
		logic [30:0] angle;
		logic [29:0] nmi;
		logic [31:0] brg;
	} geo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] start_latitude = '0;
	logic signed [31:0] start_longitude = '0;
	logic signed [31:0] end_latitude = '0;
	logic signed [31:0] end_longitude = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [30:0] central_angle;
	logic [29:0] distance_nmi;
	logic [31:0] bearing;

	geo_result_t expected_geo[$];
	logic [23:0] model_radius = RADIUS_RESET;
	int errors = 0;
	int pairs_sent = 0;
	int results_seen = 0;
	int radii_used = 1;
	int cycles = 0;
	bit quiet = 1'b0;

	great_circle_distance_bearing #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_latitude(start_latitude), .start_longitude(start_longitude),
		.end_latitude(end_latitude), .end_longitude(end_longitude),
		.out_valid(out_valid), .out_ready(out_ready),
		.central_angle(central_angle), .distance_nmi(distance_nmi), .bearing(bearing)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Rotation CORDIC: Q30 cosine and sine of a binary angle
	task automatic cordic_sin_cos(input logic [31:0] ang, output longint co,
			output longint si);
		logic [31:0] folded;
		logic flip;
		longint x, y, z, ddx, ddy;
		folded = ang;
		flip = (ang + gcdb_pkg::QUARTER_TURN) > gcdb_pkg::HALF_TURN;
		if (flip)
			folded = ang + gcdb_pkg::HALF_TURN;
		x = 652032874;
		y = 0;
		z = longint'(int'(folded));
		for (int i = 0; i < STAGES; i++) begin
			ddx = y >>> i;
			ddy = x >>> i;
			if (z >= 0) begin
				x -= ddx; y += ddy; z -= longint'(gcdb_pkg::ATAN_TURNS[i]);
			end else begin
				x += ddx; y -= ddy; z += longint'(gcdb_pkg::ATAN_TURNS[i]);
			end
		end
		co = flip ? -x : x;
		si = flip ? -y : y;
	endtask

	// Vectoring CORDIC: atan2(y, x) as a binary angle, zero vector gives 0
	function automatic logic [31:0] cordic_atan2(input longint y, input longint x);
		logic [31:0] z;
		longint ddx, ddy;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		if (x < 0) begin
			x = -x; y = -y; z = gcdb_pkg::HALF_TURN;
		end
		for (int i = 0; i < STAGES; i++) begin
			ddx = y >>> i;
			ddy = x >>> i;
			if (y > 0) begin
				x += ddx; y -= ddy; z += gcdb_pkg::ATAN_TURNS[i];
			end else begin
				x -= ddx; y += ddy; z -= gcdb_pkg::ATAN_TURNS[i];
			end
		end
		return z;
	endfunction

	// Floored integer square root
	function automatic logic [63:0] isqrt_floor(input logic [63:0] v);
		logic [63:0] r, b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Expected angle, distance and bearing for one point pair
	task automatic predict_geo(input logic [31:0] la1, input logic [31:0] lo1,
			input logic [31:0] la2, input logic [31:0] lo2, output geo_result_t res);
		longint c1, s1, c2, s2, cg1, sg1, cg2, sg2, cd, sd;
		longint r, ddx, ddy, ddz, e, n, t;
		logic [63:0] sum, q, h, rq, r2, a2, a, central, dist_nmi;
		logic [31:0] hb;
		cordic_sin_cos(la1, c1, s1);
		cordic_sin_cos(lo1, cg1, sg1);
		cordic_sin_cos(la2, c2, s2);
		cordic_sin_cos(lo2, cg2, sg2);
		r = longint'(model_radius);
		ddx = ((r * ((c2 * cg2) >>> 30)) >>> 24) - ((r * ((c1 * cg1) >>> 30)) >>> 24);
		ddy = ((r * ((c2 * sg2) >>> 30)) >>> 24) - ((r * ((c1 * sg1) >>> 30)) >>> 24);
		ddz = ((r * s2) >>> 24) - ((r * s1) >>> 24);
		sum = 64'(ddx * ddx) + 64'(ddy * ddy) + 64'(ddz * ddz);
		q = sum >> 2;
		h = isqrt_floor(q);
		rq = 64'(model_radius) << 6;
		r2 = rq * rq;
		a2 = (r2 > q) ? r2 - q : '0;
		a = isqrt_floor(a2);
		hb = cordic_atan2(longint'(h), longint'(a));
		// clamp a negative CORDIC residue, saturate at half a turn
		central = hb[31] ? '0 : 64'(hb) * 2;
		if (central > 64'h7FFF_FFFF)
			central = 64'h7FFF_FFFF;
		dist_nmi = (central * 64'(gcdb_pkg::NMI_DEG_PER_TURN)
			+ 64'(gcdb_pkg::ROUND_HALF)) >> 16;
		cordic_sin_cos(lo2 - lo1, cd, sd);
		e = (sd * c2) >>> 30;
		t = (c2 * cd) >>> 30;
		n = (c1 * s2 - s1 * t) >>> 30;
		res.angle = central[30:0];
		res.nmi = dist_nmi[29:0];
		res.brg = gcdb_pkg::QUARTER_TURN - cordic_atan2(n, e);
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Send one point pair and queue its expected result
	task automatic send_pair(input logic [31:0] la1, input logic [31:0] lo1,
			input logic [31:0] la2, input logic [31:0] lo2);
		geo_result_t res;
		predict_geo(la1, lo1, la2, lo2, res);
		expected_geo.push_back(res);
		start_latitude = la1;
		start_longitude = lo1;
		end_latitude = la2;
		end_longitude = lo2;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pairs_sent++;
		@(negedge clk);
		in_valid = 1'b0;
		repeat (pick_gap()) @(negedge clk);
	endtask

	task automatic drain();
		while (expected_geo.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	// Load a new radius once the pipeline is empty
	task automatic set_radius(input logic [23:0] rad);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = rad;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		model_radius = rad;
		radii_used++;
	endtask

	function automatic logic [31:0] rand_lat();
		return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
	endfunction

	task automatic test_special_points();
		send_pair(0, 0, 0, 0);
		send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
		send_pair(LAT_MAX, 0, LAT_MIN, 0);
		send_pair(LAT_MIN, LON_MIN, LAT_MAX, LON_MAX);
		send_pair(32'h1000_0000, 0, LAT_MAX, 32'h2000_0000);
		send_pair(0, 0, 0, LON_MIN);
		send_pair(0, LON_MAX, 0, LON_MIN);
		send_pair(0, 0, 0, 32'h4000_0000);
		send_pair(0, 0, 0, 32'hC000_0000);
		send_pair(32'h2000_0000, 32'h0000_0001, 32'hE000_0000, 32'h8000_0001);
		send_pair(32'h3FFF_FFFF, 32'hFFFF_FFFF, 32'hC000_0001, 32'h7FFF_FFFE);
		send_pair(0, 0, 1, 0);
		send_pair(0, 0, 0, 1);
	endtask

	task automatic test_radius_extremes();
		set_radius(RADIUS_MIN);
		send_pair(0, 0, 0, LON_MIN);
		send_pair(LAT_MAX, 0, 32'h0100_0000, 32'h5555_5555);
		send_pair(32'hF000_0000, 32'h1000_0000, 32'h2000_0000, 32'hA000_0000);
		set_radius(RADIUS_MAX);
		send_pair(0, 0, 0, LON_MIN);
		send_pair(LAT_MIN, 32'h7000_0000, 32'h3000_0000, 32'h9000_0000);
		send_pair(0, 0, 0, 32'h0000_1000);
	endtask

	task automatic test_random_pairs(input int count);
		int kind;
		logic [31:0] la1, lo1, la2, lo2;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(9);
			la1 = rand_lat();
			lo1 = $urandom();
			la2 = rand_lat();
			lo2 = $urandom();
			// mix in near-coincident, near-antipodal and polar pairs
			if (kind == 0) begin
				la2 = la1 + $urandom_range(15) - 7;
				lo2 = lo1 + $urandom_range(255) - 128;
			end else if (kind == 1) begin
				la2 = -la1;
				lo2 = lo1 + gcdb_pkg::HALF_TURN + $urandom_range(63) - 32;
			end else if (kind == 2) begin
				la2 = $urandom_range(1) ? LAT_MAX : LAT_MIN;
			end
			if (i % 200 == 100)
				quiet = ~quiet;
			if (i == count / 2)
				drain();
			send_pair(la1, lo1, la2, lo2);
		end
		quiet = 1'b0;
	endtask

	// Random result-side stalls
	initial begin
		forever begin
			@(negedge clk);
			if (quiet || $urandom_range(99) < 75) begin
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b0;
				repeat ($urandom_range(99) < 90 ? $urandom_range(3) : $urandom_range(40, 10))
					@(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		geo_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_geo.size() == 0) begin
				errors++;
				$display("%0t: unexpected result angle=%h dist=%h bearing=%h",
					$time, central_angle, distance_nmi, bearing);
			end else begin
				exp_res = expected_geo.pop_front();
				if (central_angle !== exp_res.angle) begin
					errors++;
					$display("%0t: central_angle expected %h actual %h",
						$time, exp_res.angle, central_angle);
				end
				if (distance_nmi !== exp_res.nmi) begin
					errors++;
					$display("%0t: distance_nmi expected %h actual %h",
						$time, exp_res.nmi, distance_nmi);
				end
				if (bearing !== exp_res.brg) begin
					errors++;
					$display("%0t: bearing expected %h actual %h",
						$time, exp_res.brg, bearing);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, expected_geo.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_special_points();
		test_radius_extremes();
		set_radius(RADIUS_RESET);
		test_random_pairs(800);
		set_radius(24'd4096);
		test_random_pairs(300);
		set_radius(24'($urandom_range(RADIUS_MAX, RADIUS_MIN)));
		test_random_pairs(300);
		set_radius(RADIUS_MAX);
		test_random_pairs(200);
		drain();
		$display("Sent %0d point pairs over %0d radius settings, checked %0d results",
			pairs_sent, radii_used, results_seen);
		$display("Covered poles, antipodes, coincident points and full lon range");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
